// File: src/mpwg_pkg.sv
package mpwg_pkg;

    // Fixed field widths of the channels
    localparam int IN_W     = 16;
    localparam int OUT_XY_W = 10;
    localparam int OUT_Z_W  = 3;

    // Default sizing
    localparam int DEF_THREAD_BUDGET = 512;
    localparam int DEF_BASE_GROUP    = 128;
    localparam int DEF_GRID_BITS     = 16;

    // Number of base shapes (BASE>>k by 1<<k)
    localparam int SHAPE_COUNT = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ZMOD,
        ST_SETUP,
        ST_LIN_T,
        ST_LIN_CHK,
        ST_LIN_MOD,
        ST_PX,
        ST_PY,
        ST_MULA,
        ST_MULB,
        ST_EVAL,
        ST_SC_ROW,
        ST_SC_AREA,
        ST_SC_COL,
        ST_FINISH
    } mpwg_state_t;

endpackage

// File: src/mpwg_grid_if.sv
interface mpwg_grid_if
    import mpwg_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] grid_x;
    logic [IN_W-1:0] grid_y;
    logic [IN_W-1:0] grid_z;

    modport source (output valid, grid_x, grid_y, grid_z, input ready);
    modport sink   (input valid, grid_x, grid_y, grid_z, output ready);
endinterface

// File: src/mpwg_group_if.sv
interface mpwg_group_if
    import mpwg_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OUT_XY_W-1:0] group_x;
    logic [OUT_XY_W-1:0] group_y;
    logic [OUT_Z_W-1:0]  group_z;

    modport source (output valid, group_x, group_y, group_z, input ready);
    modport sink   (input valid, group_x, group_y, group_z, output ready);
endinterface

// File: src/min_padding_workgroup_pick.sv
// Work-group size picker. Each transfer on grid yields one transfer on wg.
// Depth is 4, 2, 3 or 1 by divisibility of grid_z; the x*y budget is
// THREAD_BUDGET/depth. Planar mode searches the base shapes for the least
// padding penalty, then scans their multiples for the first that meets it;
// linear mode scans multiples of BASE_GROUP along x. Planar grids up to
// 16 by 8 get 16 by 8, and linear grids up to BASE_GROUP wide get
// BASE_GROUP, with no search. All remainders go through one bit-serial
// remainder unit and all products through one shared multiplier.
// grid.ready is high only while idle.
module min_padding_workgroup_pick
    import mpwg_pkg::*;
#(
    parameter int THREAD_BUDGET = DEF_THREAD_BUDGET,
    parameter int BASE_GROUP    = DEF_BASE_GROUP,
    parameter int GRID_BITS     = DEF_GRID_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    mpwg_grid_if.sink    grid,
    mpwg_group_if.source wg
);
    localparam int GW    = GRID_BITS;
    localparam int MAXS  = (THREAD_BUDGET > BASE_GROUP) ? THREAD_BUDGET : BASE_GROUP;
    localparam int SW    = $clog2(MAXS + 1);
    localparam int CW    = SW + 1;
    localparam int MBW   = (GW + 1 > CW) ? GW + 1 : CW;
    localparam int PW    = CW + MBW;
    localparam int AW    = PW + 1;
    localparam int KW    = $clog2(SHAPE_COUNT);

    mpwg_state_t state_reg, state_next;

    logic              linear_reg;
    logic              issued_reg, issued_next;
    logic              phase_reg, phase_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [GW-1:0]     gx_reg, gx_next, gy_reg, gy_next, gz_reg, gz_next;
    logic [OUT_Z_W-1:0] depth_reg, depth_next;
    logic [CW-1:0]     budget_reg, budget_next;
    logic [CW-1:0]     sx_reg, sx_next, sy_reg, sy_next;
    logic [CW-1:0]     cx_reg, cx_next, cy_reg, cy_next;
    logic [CW-1:0]     cand_reg, cand_next, best_reg, best_next;
    logic [CW-1:0]     rx_reg, rx_next, ry_reg, ry_next;
    logic [SW-1:0]     px_reg, px_next, py_reg, py_next, target_reg, target_next;
    logic [AW-1:0]     acc_reg, acc_next, least_reg, least_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_XY_W-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [OUT_Z_W-1:0]  out_z_reg, out_z_next;

    logic          mod_start, mod_busy, mod_done;
    logic [GW-1:0] mod_dividend;
    logic [SW-1:0] mod_divisor, mod_rem, pad;
    logic [CW-1:0] mul_a;
    logic [MBW-1:0] mul_b;
    logic [PW-1:0] product;
    logic [GW+IN_W-1:0] ext_x, ext_y, ext_z;
    logic [CW+OUT_XY_W-1:0] ext_rx, ext_ry;

    function automatic logic [CW-1:0] shape_x(input logic [KW-1:0] k);
        logic [CW-1:0] v;
        v = CW'(BASE_GROUP >> k);
        return (v == '0) ? CW'(1) : v;
    endfunction

    function automatic logic [CW-1:0] shape_y(input logic [KW-1:0] k);
        return CW'(1) << k;
    endfunction

    mpwg_mod_unit #(
        .GW (GW),
        .SW (SW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .divisor  (mod_divisor),
        .busy     (mod_busy),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign pad     = (mod_rem == '0) ? '0 : SW'(mod_divisor - mod_rem);
    assign product = PW'(mul_a) * PW'(mul_b);

    // input masking to GRID_BITS
    assign ext_x = {{GW{1'b0}}, grid.grid_x};
    assign ext_y = {{GW{1'b0}}, grid.grid_y};
    assign ext_z = {{GW{1'b0}}, grid.grid_z};
    assign ext_rx = {{OUT_XY_W{1'b0}}, rx_reg};
    assign ext_ry = {{OUT_XY_W{1'b0}}, ry_reg};

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            linear_reg <= 1'b0;
        else if (cfg_wr_en)
            linear_reg <= cfg_wr_data;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        phase_reg  <= phase_next;
        k_reg      <= k_next;
        gx_reg     <= gx_next;
        gy_reg     <= gy_next;
        gz_reg     <= gz_next;
        depth_reg  <= depth_next;
        budget_reg <= budget_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cand_reg   <= cand_next;
        best_reg   <= best_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        target_reg <= target_next;
        acc_reg    <= acc_next;
        least_reg  <= least_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_z_reg  <= out_z_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        k_next         = k_reg;
        gx_next        = gx_reg;
        gy_next        = gy_reg;
        gz_next        = gz_reg;
        depth_next     = depth_reg;
        budget_next    = budget_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cand_next      = cand_reg;
        best_next      = best_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        target_next    = target_reg;
        acc_next       = acc_reg;
        least_next     = least_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;
        mod_start      = 1'b0;
        mod_dividend   = gx_reg;
        mod_divisor    = SW'(cx_reg);
        mul_a          = CW'(px_reg);
        mul_b          = MBW'(gy_reg);
        grid.ready     = (state_reg == ST_IDLE);

        if (out_valid_reg && wg.ready)
            out_valid_next = 1'b0;

        // operand selection for the remainder unit
        case (state_reg)
            ST_ZMOD:
            begin
                mod_dividend = gz_reg;
                mod_divisor  = SW'(3);
            end
            ST_LIN_T:   mod_divisor = SW'(BASE_GROUP);
            ST_LIN_MOD: mod_divisor = SW'(cand_reg);
            ST_PY:
            begin
                mod_dividend = gy_reg;
                mod_divisor  = SW'(cy_reg);
            end
            default: ;
        endcase

        // issue once in each remainder state
        case (state_reg)
            ST_ZMOD, ST_LIN_T, ST_LIN_MOD, ST_PX, ST_PY:
            begin
                if (!issued_reg)
                begin
                    mod_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mod_done)
                    issued_next = 1'b0;
            end
            default: ;
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if (grid.valid)
                begin
                    gx_next    = ext_x[GW-1:0];
                    gy_next    = ext_y[GW-1:0];
                    gz_next    = ext_z[GW-1:0];
                    state_next = ST_ZMOD;
                end
            end
            ST_ZMOD:
            begin
                if (issued_reg && mod_done)
                begin
                    if (gz_reg[1:0] == 2'b00)
                        depth_next = OUT_Z_W'(4);
                    else if (gz_reg[0] == 1'b0)
                        depth_next = OUT_Z_W'(2);
                    else if (mod_rem == '0)
                        depth_next = OUT_Z_W'(3);
                    else
                        depth_next = OUT_Z_W'(1);
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                case (depth_reg)
                    OUT_Z_W'(4): budget_next = CW'(THREAD_BUDGET / 4);
                    OUT_Z_W'(2): budget_next = CW'(THREAD_BUDGET / 2);
                    OUT_Z_W'(3): budget_next = CW'(THREAD_BUDGET / 3);
                    default:     budget_next = CW'(THREAD_BUDGET);
                endcase
                if (linear_reg)
                begin
                    ry_next = CW'(1);
                    if (32'(gx_reg) <= 32'(BASE_GROUP))
                    begin
                        rx_next    = CW'(BASE_GROUP);
                        state_next = ST_FINISH;
                    end
                    else
                        state_next = ST_LIN_T;
                end
                else if (32'(gx_reg) <= 32'd16 && 32'(gy_reg) <= 32'd8)
                begin
                    rx_next    = CW'(16);
                    ry_next    = CW'(8);
                    state_next = ST_FINISH;
                end
                else
                begin
                    phase_next = 1'b0;
                    k_next     = '0;
                    least_next = '1;
                    cx_next    = shape_x(KW'(0));
                    cy_next    = shape_y(KW'(0));
                    state_next = ST_PX;
                end
            end
            ST_LIN_T:
            begin
                if (issued_reg && mod_done)
                begin
                    target_next = pad;
                    cand_next   = CW'(2 * BASE_GROUP);
                    best_next   = CW'(BASE_GROUP);
                    state_next  = ST_LIN_CHK;
                end
            end
            ST_LIN_CHK:
            begin
                if (cand_reg <= budget_reg)
                    state_next = ST_LIN_MOD;
                else
                begin
                    rx_next    = best_reg;
                    state_next = ST_FINISH;
                end
            end
            ST_LIN_MOD:
            begin
                if (issued_reg && mod_done)
                begin
                    if (pad == target_reg)
                        best_next = cand_reg;
                    cand_next  = cand_reg + CW'(BASE_GROUP);
                    state_next = ST_LIN_CHK;
                end
            end
            ST_PX:
            begin
                if (issued_reg && mod_done)
                begin
                    px_next    = pad;
                    state_next = ST_PY;
                end
            end
            ST_PY:
            begin
                if (issued_reg && mod_done)
                begin
                    py_next    = pad;
                    state_next = ST_MULA;
                end
            end
            // penalty = px*gy + py*(gx+px)
            ST_MULA:
            begin
                acc_next   = AW'(product);
                state_next = ST_MULB;
            end
            ST_MULB:
            begin
                mul_a      = CW'(py_reg);
                mul_b      = MBW'(gx_reg) + MBW'(px_reg);
                acc_next   = acc_reg + AW'(product);
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!phase_reg)
                begin
                    if (acc_reg < least_reg)
                        least_next = acc_reg;
                    if (k_reg == KW'(SHAPE_COUNT - 1))
                    begin
                        phase_next = 1'b1;
                        k_next     = '0;
                        sx_next    = shape_x(KW'(0));
                        sy_next    = shape_y(KW'(0));
                        cx_next    = shape_x(KW'(0));
                        cy_next    = shape_y(KW'(0));
                        state_next = ST_SC_ROW;
                    end
                    else
                    begin
                        k_next     = k_reg + KW'(1);
                        cx_next    = shape_x(k_reg + KW'(1));
                        cy_next    = shape_y(k_reg + KW'(1));
                        state_next = ST_PX;
                    end
                end
                else if (acc_reg == least_reg)
                begin
                    rx_next    = cx_reg;
                    ry_next    = cy_reg;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cx_next    = cx_reg + sx_reg;
                    state_next = ST_SC_AREA;
                end
            end
            ST_SC_ROW:
            begin
                if (cy_reg <= budget_reg)
                    state_next = ST_SC_AREA;
                else if (k_reg == KW'(SHAPE_COUNT - 1))
                begin
                    rx_next    = '0;
                    ry_next    = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    k_next  = k_reg + KW'(1);
                    sx_next = shape_x(k_reg + KW'(1));
                    sy_next = shape_y(k_reg + KW'(1));
                    cx_next = shape_x(k_reg + KW'(1));
                    cy_next = shape_y(k_reg + KW'(1));
                end
            end
            ST_SC_AREA:
            begin
                mul_a      = cx_reg;
                mul_b      = MBW'(cy_reg);
                acc_next   = AW'(product);
                state_next = ST_SC_COL;
            end
            ST_SC_COL:
            begin
                if (cx_reg <= budget_reg && acc_reg <= AW'(budget_reg))
                    state_next = ST_PX;
                else
                begin
                    cy_next    = cy_reg + sy_reg;
                    cx_next    = sx_reg;
                    state_next = ST_SC_ROW;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || wg.ready)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = ext_rx[OUT_XY_W-1:0];
                    out_y_next     = ext_ry[OUT_XY_W-1:0];
                    out_z_next     = depth_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign wg.valid   = out_valid_reg;
    assign wg.group_x = out_x_reg;
    assign wg.group_y = out_y_reg;
    assign wg.group_z = out_z_reg;

    // remainder unit is quiet whenever the sequencer is idle
    a_idle_mod_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !mod_busy)
        else $error("remainder unit busy while idle");

    // a finished remainder always belongs to an issued request
    a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> issued_reg)
        else $error("remainder done without request");

    a_depth_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_z_reg == OUT_Z_W'(1) || out_z_reg == OUT_Z_W'(2) ||
                           out_z_reg == OUT_Z_W'(3) || out_z_reg == OUT_Z_W'(4)))
        else $error("illegal group depth");

    a_linear_height: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && linear_reg |-> out_y_reg == OUT_XY_W'(1))
        else $error("linear result with height other than one");
endmodule

// File: src/mpwg_mod_unit.sv
// Restoring remainder unit: one dividend bit per cycle.
module mpwg_mod_unit
    import mpwg_pkg::*;
#(
    parameter int GW = DEF_GRID_BITS,
    parameter int SW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [GW-1:0] dividend,
    input  logic [SW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [SW-1:0] rem
);
    localparam int CNT_W = (GW > 1) ? $clog2(GW) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [GW-1:0]    q_reg, q_next;
    logic [SW-1:0]    d_reg, d_next;
    logic [SW-1:0]    r_reg, r_next;
    logic [SW:0]      trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        d_reg <= d_next;
        r_reg <= r_next;
    end

    // shift in next dividend bit, subtract when it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        trial     = {r_reg, q_reg[GW-1]};
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                cnt_next  = '0;
                q_next    = dividend;
                d_next    = divisor;
                r_next    = '0;
            end
        end
        else
        begin
            q_next = q_reg << 1;
            if (trial >= {1'b0, d_reg})
                r_next = SW'(trial - {1'b0, d_reg});
            else
                r_next = trial[SW-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(GW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = r_reg;
endmodule

// File: verif/tb.sv
module tb;
    import mpwg_pkg::*;

    typedef enum bit {MODE_PLANAR = 1'b0, MODE_LINEAR = 1'b1} mode_t;

    typedef struct packed {
        logic [OUT_XY_W-1:0] gx;
        logic [OUT_XY_W-1:0] gy;
        logic [OUT_Z_W-1:0]  gz;
    } wg_size_t;

    localparam int BUDGET = DEF_THREAD_BUDGET;
    localparam int BASE   = DEF_BASE_GROUP;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    mpwg_grid_if  grid_ch();
    mpwg_group_if wg_ch();

    min_padding_workgroup_pick dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .grid        (grid_ch.sink),
        .wg          (wg_ch.source)
    );

    mode_t    cur_mode;
    wg_size_t pending_sizes[$];
    int       err_count = 0;
    bit       calm;

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Padding of one axis
    function automatic longint axis_pad(longint g, longint s);
        longint r;
        r = g % s;
        return (r == 0) ? 0 : s - r;
    endfunction

    function automatic longint plane_pad(longint gx, longint gy, longint sx, longint sy);
        longint px;
        longint py;
        px = axis_pad(gx, sx);
        py = axis_pad(gy, sy);
        return px * gy + py * gx + px * py;
    endfunction

    // Expected work-group size for one grid
    function automatic wg_size_t pick_size(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                           mode_t m);
        wg_size_t r;
        longint gx, gy, gz, depth, budget, rx, ry, least, p, sx, sy, cx, cy, best, target;
        bit found;
        gx = x;
        gy = y;
        gz = z;
        rx = 0;
        ry = 0;
        found = 0;
        if (gz % 4 == 0) depth = 4;
        else if (gz % 2 == 0) depth = 2;
        else if (gz % 3 == 0) depth = 3;
        else depth = 1;
        budget = BUDGET / depth;
        if (m == MODE_LINEAR) begin
            ry = 1;
            if (gx <= BASE) begin
                rx = BASE;
            end
            else begin
                best = BASE;
                target = axis_pad(gx, BASE);
                for (longint k = 2; k * BASE <= budget; k++)
                    if (axis_pad(gx, k * BASE) == target) best = k * BASE;
                rx = best;
            end
        end
        else if (gx <= 16 && gy <= 8) begin
            rx = 16;
            ry = 8;
        end
        else begin
            least = 64'h7fff_ffff_ffff_ffff;
            for (int k = 0; k < SHAPE_COUNT; k++) begin
                p = plane_pad(gx, gy, BASE >> k, 1 << k);
                if (p < least) least = p;
            end
            for (int k = 0; k < SHAPE_COUNT && !found; k++) begin
                sx = BASE >> k;
                sy = 1 << k;
                for (longint my = 1; my * sy <= budget && !found; my++) begin
                    cy = my * sy;
                    for (longint mx = 1; mx * sx <= budget; mx++) begin
                        cx = mx * sx;
                        if (cx * cy > budget) break;
                        if (plane_pad(gx, gy, cx, cy) == least) begin
                            rx = cx;
                            ry = cy;
                            found = 1;
                            break;
                        end
                    end
                end
            end
        end
        r.gx = rx[OUT_XY_W-1:0];
        r.gy = ry[OUT_XY_W-1:0];
        r.gz = depth[OUT_Z_W-1:0];
        return r;
    endfunction

    // Send one grid; record the expected size at the transfer.
    // valid stays high afterwards; set_mode drops it, and the next call drives a new grid or drops it first.
    task automatic send_grid(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        while (!calm && $urandom_range(99) < 6) begin
            grid_ch.valid  <= 1'b0;
            grid_ch.grid_x <= 16'($urandom);
            grid_ch.grid_y <= 16'($urandom);
            grid_ch.grid_z <= 16'($urandom);
            @(negedge clk);
        end
        grid_ch.valid  <= 1'b1;
        grid_ch.grid_x <= x;
        grid_ch.grid_y <= y;
        grid_ch.grid_z <= z;
        @(posedge clk);
        while (!grid_ch.ready) @(posedge clk);
        pending_sizes = {pending_sizes, pick_size(x, y, z, cur_mode)};
        @(negedge clk);
    endtask

    // Write the mode register once the block has drained
    task automatic set_mode(mode_t m);
        grid_ch.valid <= 1'b0;
        wait (pending_sizes.size() == 0);
        repeat (8) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cur_mode = m;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
    endtask

    task automatic test_planar_corners();
        set_mode(MODE_PLANAR);
        send_grid(1, 1, 1);
        send_grid(16, 8, 1);
        send_grid(17, 8, 2);
        send_grid(16, 9, 3);
        send_grid(0, 0, 0);
        send_grid(0, 5, 7);
        send_grid(100, 37, 4);
        send_grid(1000, 3, 6);
        send_grid(3, 1000, 9);
        send_grid(65535, 1, 12);
        send_grid(1, 65535, 5);
        send_grid(65535, 65535, 65535);
    endtask

    task automatic test_linear_corners();
        set_mode(MODE_LINEAR);
        send_grid(1, 1, 1);
        send_grid(128, 1, 2);
        send_grid(129, 7, 3);
        send_grid(0, 0, 0);
        send_grid(384, 5, 4);
        send_grid(512, 1, 6);
        send_grid(640, 1, 1);
        send_grid(1536, 9, 3);
        send_grid(65535, 65535, 65535);
    endtask

    // Mostly modest grids, some across the full field range
    task automatic test_random(mode_t m, int count);
        logic [15:0] x, y, z;
        set_mode(m);
        for (int i = 0; i < count; i++) begin
            calm = (i >= count / 3 && i < count / 2);
            if ($urandom_range(99) < 70) begin
                x = 16'($urandom_range(300));
                y = 16'($urandom_range(300));
                z = 16'($urandom_range(24));
            end
            else begin
                x = 16'($urandom);
                y = 16'($urandom);
                z = 16'($urandom);
            end
            send_grid(x, y, z);
        end
        calm = 0;
    endtask

    // Result receiver stalls
    always @(negedge clk)
        wg_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);

    // Result checker
    always @(posedge clk) begin
        wg_size_t want;
        if (rst_n && wg_ch.valid && wg_ch.ready) begin
            if (pending_sizes.size() == 0) begin
                $error("unexpected result transfer");
                err_count++;
            end
            else begin
                want = pending_sizes.pop_front();
                if (wg_ch.group_x !== want.gx) begin
                    $error("group_x: expected %0d, got %0d", want.gx, wg_ch.group_x);
                    err_count++;
                end
                if (wg_ch.group_y !== want.gy) begin
                    $error("group_y: expected %0d, got %0d", want.gy, wg_ch.group_y);
                    err_count++;
                end
                if (wg_ch.group_z !== want.gz) begin
                    $error("group_z: expected %0d, got %0d", want.gz, wg_ch.group_z);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #200000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        calm           = 0;
        cur_mode       = MODE_PLANAR;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        grid_ch.valid  = 1'b0;
        grid_ch.grid_x = '0;
        grid_ch.grid_y = '0;
        grid_ch.grid_z = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_planar_corners();
        test_linear_corners();
        test_random(MODE_PLANAR, 150);
        test_random(MODE_LINEAR, 140);
        test_random(MODE_PLANAR, 150);
        test_random(MODE_LINEAR, 140);

        grid_ch.valid <= 1'b0;
        wait (pending_sizes.size() == 0);
        repeat (100) @(posedge clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
